FILE: rtl/sdfp_pkg.sv
// Shared types and character codes for the SSE data frame parser.
package sdfp_pkg;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
  } res_t;

  // One queue entry: the one or two results caused by one input word.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

endpackage

FILE: rtl/sdfp_front.sv
// Front end: accepts stream words, tracks line state and classifies each byte.
module sdfp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_func,
  input  logic [7:0]           in_stream_byte,
  output logic                 in_full,
  input  logic                 q_full,
  output logic                 q_push,
  output sdfp_pkg::entry_t     q_entry
);

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_NAME   = 3'd1;
  localparam logic [2:0] PH_VSTART = 3'd2;
  localparam logic [2:0] PH_VALUE  = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] NAME_LEN  = 3'd4;

  function automatic logic [7:0] name_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h64;
      2'd1:    c = 8'h61;
      2'd2:    c = 8'h74;
      2'd3:    c = 8'h61;
      default: c = 8'h61;
    endcase
    return c;
  endfunction

  logic [2:0] phase_r, phase_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       match_r, match_nxt;
  logic       pcr_r, pcr_nxt;
  logic       fhd_r, fhd_nxt;

  logic       acc;
  logic       name_hit;
  logic [1:0] n;
  sdfp_pkg::res_t ra, rb;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;
  assign name_hit = (pos_r < NAME_LEN) && match_r &&
                    (in_stream_byte == name_char(pos_r[1:0]));

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    match_nxt = match_r;
    pcr_nxt   = pcr_r;
    fhd_nxt   = fhd_r;
    n         = 2'd0;
    ra        = '{kind: sdfp_pkg::KIND_BYTE, payload: 8'h00};
    rb        = '{kind: sdfp_pkg::KIND_BYTE, payload: 8'h00};
    if (in_func) begin
      if (fhd_r) begin
        ra = '{kind: sdfp_pkg::KIND_ABORT, payload: 8'h00};
        n  = 2'd1;
      end
      phase_nxt = PH_START;
      pos_nxt   = 3'd0;
      match_nxt = 1'b1;
      pcr_nxt   = 1'b0;
      fhd_nxt   = 1'b0;
    end else if (in_stream_byte == sdfp_pkg::CH_LF) begin
      if (phase_r == PH_START && fhd_r) begin
        ra      = '{kind: sdfp_pkg::KIND_FRAME, payload: 8'h00};
        n       = 2'd1;
        fhd_nxt = 1'b0;
      end
      phase_nxt = PH_START;
      pos_nxt   = 3'd0;
      match_nxt = 1'b1;
      pcr_nxt   = 1'b0;
    end else begin
      case (phase_r)
        PH_START: begin
          if (pcr_r) begin
            // CR not followed by LF: this line can never be a data line
            pcr_nxt   = 1'b0;
            phase_nxt = PH_SKIP;
          end else if (in_stream_byte == sdfp_pkg::CH_CR) begin
            pcr_nxt = 1'b1;
          end else if (in_stream_byte == sdfp_pkg::CH_COLON) begin
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_NAME;
            if (name_hit) pos_nxt = pos_r + 3'd1;
            else          match_nxt = 1'b0;
          end
        end
        PH_NAME: begin
          if (in_stream_byte == sdfp_pkg::CH_COLON) begin
            if (match_r && pos_r == NAME_LEN) begin
              if (fhd_r) begin
                ra = '{kind: sdfp_pkg::KIND_BYTE, payload: sdfp_pkg::CH_LF};
                n  = 2'd1;
              end
              fhd_nxt   = 1'b1;
              phase_nxt = PH_VSTART;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end else begin
            if (name_hit) pos_nxt = pos_r + 3'd1;
            else          match_nxt = 1'b0;
          end
        end
        PH_VSTART: begin
          phase_nxt = PH_VALUE;
          if (in_stream_byte == sdfp_pkg::CH_CR) begin
            pcr_nxt = 1'b1;
          end else if (in_stream_byte != sdfp_pkg::CH_SPACE) begin
            ra = '{kind: sdfp_pkg::KIND_BYTE, payload: in_stream_byte};
            n  = 2'd1;
          end
        end
        PH_VALUE: begin
          if (pcr_r) begin
            // release the held CR ahead of this byte
            ra = '{kind: sdfp_pkg::KIND_BYTE, payload: sdfp_pkg::CH_CR};
            if (in_stream_byte == sdfp_pkg::CH_CR) begin
              n = 2'd1;
            end else begin
              rb = '{kind: sdfp_pkg::KIND_BYTE, payload: in_stream_byte};
              n  = 2'd2;
            end
          end else if (in_stream_byte != sdfp_pkg::CH_CR) begin
            ra = '{kind: sdfp_pkg::KIND_BYTE, payload: in_stream_byte};
            n  = 2'd1;
          end
          pcr_nxt = (in_stream_byte == sdfp_pkg::CH_CR);
        end
        default: begin
          phase_nxt = PH_SKIP;
        end
      endcase
    end
  end

  assign q_push  = acc && (n != 2'd0);
  assign q_entry = '{two: (n == 2'd2), r0: ra, r1: rb};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      pos_r   <= 3'd0;
      match_r <= 1'b1;
      pcr_r   <= 1'b0;
      fhd_r   <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
      pcr_r   <= pcr_nxt;
      fhd_r   <= fhd_nxt;
    end
  end

  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_func) |=> (!fhd_r && !pcr_r && phase_r == PH_START))
    else $error("reset word did not clear parser state");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= NAME_LEN)
    else $error("name position beyond field name length");

endmodule

FILE: rtl/sdfp_queue.sv
// Short queue of result entries between front end and back end.
module sdfp_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sdfp_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output sdfp_pkg::entry_t rd_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  sdfp_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign rd_entry = mem_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == LAST_IDX) ? '0 : wp_r + PW'(1);
      if (do_pop)  rp_r <= (rp_r == LAST_IDX) ? '0 : rp_r + PW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule

FILE: rtl/sdfp_back.sv
// Back end: splits queue entries into single results behind an output register.
module sdfp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  sdfp_pkg::entry_t q_entry,
  output logic             q_pop,
  input  logic             out_pop,
  output logic             out_empty,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_payload,
  output logic             out_last
);

  logic           vld_r, vld_nxt;
  logic           sec_pend_r, sec_pend_nxt;
  sdfp_pkg::res_t sec_r, sec_nxt;
  sdfp_pkg::res_t res_r, res_nxt;
  logic           last_r, last_nxt;
  logic           load;

  assign load = !vld_r || out_pop;

  always_comb begin
    vld_nxt      = vld_r;
    sec_pend_nxt = sec_pend_r;
    sec_nxt      = sec_r;
    res_nxt      = res_r;
    last_nxt     = last_r;
    q_pop        = 1'b0;
    if (load) begin
      if (sec_pend_r) begin
        res_nxt      = sec_r;
        last_nxt     = 1'b1;
        vld_nxt      = 1'b1;
        sec_pend_nxt = 1'b0;
      end else if (!q_empty) begin
        res_nxt      = q_entry.r0;
        last_nxt     = !q_entry.two;
        vld_nxt      = 1'b1;
        sec_nxt      = q_entry.r1;
        sec_pend_nxt = q_entry.two;
        q_pop        = 1'b1;
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      sec_pend_r <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      sec_pend_r <= sec_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sec_r  <= sec_nxt;
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  assign out_empty   = !vld_r;
  assign out_kind    = res_r.kind;
  assign out_payload = res_r.payload;
  assign out_last    = last_r;

  a_second_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    sec_pend_r |-> (vld_r && !last_r))
    else $error("second result pending without a non-final first result shown");

  a_no_pop_while_second: assert property (@(posedge clk) disable iff (!rst_n)
    sec_pend_r |-> !q_pop)
    else $error("queue popped while a second result is still pending");

endmodule

FILE: rtl/sse_data_frame_parser.sv
// Top level of the SSE data frame parser: front end, entry queue and back end.
//
// Usage: push one word per cycle on the input queue port (in_push, in_func,
// in_stream_byte); a word is taken at a clock edge where in_push is high and
// in_full is low. in_func = 1 drops any partial frame and resets the parser.
// Results come out of a queue-like port: while out_empty is low, out_kind,
// out_payload and out_last show the oldest result; out_pop takes it.
// out_kind: payload byte, frame complete or frame aborted; out_last marks the
// final result of one input word (a word makes zero, one or two results).
// With the queue and output register empty, a result is written into the entry
// queue at the edge that takes its word and is then loaded into the output
// register, from which out_pop takes it.
// Words are taken one per cycle while in_full is low; results leave the output
// register one per cycle while the receiver pops, two-result words in turn.
// The entry queue (QUEUE_DEPTH entries) lets the front end keep taking words
// while the output side is stalled; when it fills, in_full rises and holds
// until the receiver pops. Reset (rst_n low, synchronous) returns the parser
// to line start with no frame open and empties the queue and output register.
module sse_data_frame_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_func,
  input  logic [7:0] in_stream_byte,
  output logic       in_full,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [1:0] out_kind,
  output logic [7:0] out_payload,
  output logic       out_last
);

  // front end to queue
  logic             q_push;
  logic             q_full;
  sdfp_pkg::entry_t q_wr_entry;

  // queue to back end
  logic             q_pop;
  logic             q_empty;
  sdfp_pkg::entry_t q_rd_entry;

  // Classify each word and hand its results to the queue as one entry.
  sdfp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_func        (in_func),
    .in_stream_byte (in_stream_byte),
    .in_full        (in_full),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_wr_entry)
  );

  // Hold entries so the front end keeps running while the receiver stalls.
  sdfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .rd_entry (q_rd_entry)
  );

  // Split each entry into single results and drive the output register.
  sdfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_entry     (q_rd_entry),
    .q_pop       (q_pop),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_kind    (out_kind),
    .out_payload (out_payload),
    .out_last    (out_last)
  );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for sse_data_frame_parser: directed table, random streams, checker.
module tb_top;

  typedef sdfp_pkg::res_t res_t;

  localparam logic [7:0] CH_LF    = sdfp_pkg::CH_LF;
  localparam logic [7:0] CH_CR    = sdfp_pkg::CH_CR;
  localparam logic [7:0] CH_SPACE = sdfp_pkg::CH_SPACE;
  localparam logic [7:0] CH_COLON = sdfp_pkg::CH_COLON;

  localparam logic [1:0] KIND_BYTE  = sdfp_pkg::KIND_BYTE;
  localparam logic [1:0] KIND_FRAME = sdfp_pkg::KIND_FRAME;
  localparam logic [1:0] KIND_ABORT = sdfp_pkg::KIND_ABORT;

  // Parser phases of the testbench's own line tracker
  typedef enum logic [2:0] {
    LINE_START,
    IN_NAME,
    VALUE_START,
    IN_VALUE,
    SKIP_LINE
  } line_phase_t;

  // One input word plus what the directed table says it must cause.
  // Rows with known = 0 are left to the line tracker.
  typedef struct packed {
    logic       func;
    logic [7:0] b;
    logic       known;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } in_word_t;

  // One result word as seen on the output port
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
    logic       last;
  } result_t;

  localparam logic [31:0] FIELD_NAME = "data";
  localparam res_t        NO_RES     = '{KIND_BYTE, 8'h00};
  localparam int          DIR_ROWS   = 30;
  localparam int          RAND_WORDS = 1850;
  localparam int          DRAIN_CYC  = 20;

  // Directed stream: extremes, CR handling, joining newline, frame end, abort
  localparam in_word_t DIR_TAB [DIR_ROWS] = '{
    '{1'b1, 8'h00,    1'b1, 2'd0, NO_RES, NO_RES},                // reset word, no frame open
    '{1'b0, "d",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, "a",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, "t",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, "a",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CH_COLON, 1'b1, 2'd0, NO_RES, NO_RES},                // first data line, no join
    '{1'b0, CH_SPACE, 1'b1, 2'd0, NO_RES, NO_RES},                // leading space dropped
    '{1'b0, 8'h00,    1'b1, 2'd1, '{KIND_BYTE, 8'h00}, NO_RES},
    '{1'b0, CH_CR,    1'b1, 2'd0, NO_RES, NO_RES},                // CR held back
    '{1'b0, CH_CR,    1'b1, 2'd1, '{KIND_BYTE, CH_CR}, NO_RES},   // CR after CR
    '{1'b0, 8'hFF,    1'b1, 2'd2, '{KIND_BYTE, CH_CR}, '{KIND_BYTE, 8'hFF}},
    '{1'b0, CH_CR,    1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CH_LF,    1'b1, 2'd0, NO_RES, NO_RES},                // CR before LF stripped
    '{1'b0, "d",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, "a",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, "t",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, "a",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CH_COLON, 1'b1, 2'd1, '{KIND_BYTE, CH_LF}, NO_RES},   // joining newline
    '{1'b0, CH_LF,    1'b0, 2'd0, NO_RES, NO_RES},                // empty value
    '{1'b0, CH_LF,    1'b1, 2'd1, '{KIND_FRAME, 8'h00}, NO_RES},  // blank line ends frame
    '{1'b0, CH_CR,    1'b0, 2'd0, NO_RES, NO_RES},                // CR at line start
    '{1'b0, "x",      1'b0, 2'd0, NO_RES, NO_RES},                //   then not LF: skip
    '{1'b0, CH_LF,    1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CH_LF,    1'b1, 2'd0, NO_RES, NO_RES},                // blank line, no data
    '{1'b0, "d",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, "a",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, "t",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, "a",      1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CH_COLON, 1'b1, 2'd0, NO_RES, NO_RES},
    '{1'b1, 8'hFF,    1'b1, 2'd1, '{KIND_ABORT, 8'h00}, NO_RES}   // reset drops open frame
  };

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       in_push        = 1'b0;
  logic       in_func        = 1'b0;
  logic [7:0] in_stream_byte = 8'h00;
  logic       in_full;
  logic       out_pop        = 1'b0;
  logic       out_empty;
  logic [1:0] out_kind;
  logic [7:0] out_payload;
  logic       out_last;

  // Line tracker state, mirrors the parser's state
  line_phase_t phase      = LINE_START;
  logic [2:0]  name_len   = 3'd0;
  logic        name_ok    = 1'b1;
  logic        cr_held    = 1'b0;
  logic        frame_open = 1'b0;

  in_word_t word_queue [$];       // words still to be pushed
  in_word_t held_word = '0;       // word currently on the input port
  result_t  expected_results [$]; // results owed by the block, oldest first

  int fail_cnt    = 0;
  int words_taken = 0;
  int bytes_seen  = 0;
  int frames_seen = 0;
  int aborts_seen = 0;
  int pop_cyc     = 0;

  sse_data_frame_parser DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_func        (in_func),
    .in_stream_byte (in_stream_byte),
    .in_full        (in_full),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_kind       (out_kind),
    .out_payload    (out_payload),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line tracker
  // ---------------------------------------------------------------------------

  // Return to line start; frame state is left alone.
  function automatic void start_line();
    phase    = LINE_START;
    name_len = 3'd0;
    name_ok  = 1'b1;
    cr_held  = 1'b0;
  endfunction

  // Advance the field-name match by one byte, or mark it as failed.
  function automatic void match_name(input logic [7:0] b);
    if (name_ok && name_len < 3'd4 && b == FIELD_NAME[8 * (3 - name_len) +: 8])
      name_len = name_len + 3'd1;
    else
      name_ok = 1'b0;
  endfunction

  // Work out the zero, one or two results that one input word causes.
  function automatic void parse_word(input logic func, input logic [7:0] b,
                                     output logic [1:0] cnt, output res_t r0,
                                     output res_t r1);
    res_t rs [2];
    int   n;
    n     = 0;
    rs[0] = NO_RES;
    rs[1] = NO_RES;
    if (func) begin
      // drop the open frame, if any, and start over
      if (frame_open) begin
        rs[n] = '{KIND_ABORT, 8'h00};
        n++;
      end
      start_line();
      frame_open = 1'b0;
    end else if (b == CH_LF) begin
      // LF on an empty line closes a frame that holds data
      if (phase == LINE_START && frame_open) begin
        rs[n] = '{KIND_FRAME, 8'h00};
        n++;
        frame_open = 1'b0;
      end
      start_line();
    end else begin
      case (phase)
        LINE_START: begin
          if (cr_held) begin
            // CR not followed by LF: the line can never be a data line
            cr_held = 1'b0;
            phase   = SKIP_LINE;
          end else if (b == CH_CR) begin
            cr_held = 1'b1;
          end else if (b == CH_COLON) begin
            phase = SKIP_LINE;
          end else begin
            phase = IN_NAME;
            match_name(b);
          end
        end
        IN_NAME: begin
          if (b == CH_COLON) begin
            if (name_ok && name_len == 3'd4) begin
              if (frame_open) begin
                rs[n] = '{KIND_BYTE, CH_LF};
                n++;
              end
              frame_open = 1'b1;
              phase      = VALUE_START;
            end else begin
              phase = SKIP_LINE;
            end
          end else begin
            match_name(b);
          end
        end
        VALUE_START: begin
          phase = IN_VALUE;
          if (b == CH_CR) begin
            cr_held = 1'b1;
          end else if (b != CH_SPACE) begin
            rs[n] = '{KIND_BYTE, b};
            n++;
          end
        end
        IN_VALUE: begin
          // release a held CR, then hold the new one or send the byte
          if (cr_held) begin
            rs[n] = '{KIND_BYTE, CH_CR};
            n++;
          end
          if (b == CH_CR) begin
            cr_held = 1'b1;
          end else begin
            cr_held = 1'b0;
            rs[n]   = '{KIND_BYTE, b};
            n++;
          end
        end
        default: phase = SKIP_LINE;
      endcase
    end
    cnt = n[1:0];
    r0  = rs[0];
    r1  = rs[1];
  endfunction

  // ---------------------------------------------------------------------------
  // Stream generation
  // ---------------------------------------------------------------------------

  task automatic add_word(input logic func, input logic [7:0] b);
    word_queue.push_back('{func, b, 1'b0, 2'd0, NO_RES, NO_RES});
  endtask

  // Mostly printable, with a fair share of CRs and arbitrary bytes
  function automatic logic [7:0] value_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14)
      return 8'($urandom_range(8'h20, 8'h7E));
    else if (r < 17)
      return CH_CR;
    else
      return 8'($urandom_range(0, 255));
  endfunction

  task automatic end_line();
    if ($urandom_range(0, 2) == 0)
      add_word(1'b0, CH_CR);
    add_word(1'b0, CH_LF);
  endtask

  task automatic add_value();
    int len;
    if ($urandom_range(0, 1) == 1)
      add_word(1'b0, CH_SPACE);
    len = $urandom_range(0, 10);
    repeat (len) add_word(1'b0, value_byte());
  endtask

  // Build a random stream: mostly data lines and blank lines so frames open and
  // close often; the rest is other fields, near-miss names, comments, lines of
  // random printable text, reset words and raw noise.
  task automatic build_stream(input int target);
    int pick;
    int len;
    while (word_queue.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        for (int i = 0; i < 4; i++)
          add_word(1'b0, FIELD_NAME[8 * (3 - i) +: 8]);
        add_word(1'b0, CH_COLON);
        add_value();
        end_line();
      end else if (pick < 65) begin
        end_line();
      end else if (pick < 76) begin
        // mutate "data": prefixes, extensions, misspellings, empty name (comment)
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          if (i < 4 && $urandom_range(0, 3) != 0)
            add_word(1'b0, FIELD_NAME[8 * (3 - i) +: 8]);
          else if ($urandom_range(0, 1) == 1)
            add_word(1'b0, 8'($urandom_range(8'h61, 8'h7A)));
          else
            add_word(1'b0, 8'($urandom_range(8'h41, 8'h5A)));
        end
        add_word(1'b0, CH_COLON);
        add_value();
        end_line();
      end else if (pick < 83) begin
        len = $urandom_range(1, 8);
        repeat (len) add_word(1'b0, 8'($urandom_range(8'h20, 8'h7E)));
        end_line();
      end else if (pick < 89) begin
        add_word(1'b1, 8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) add_word(1'b0, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps
  // ---------------------------------------------------------------------------

  task automatic send_words();
    in_word_t w;
    int       burst;
    int       gap;
    while (word_queue.size() != 0) begin
      burst = $urandom_range(1, 32);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      while (burst > 0 && word_queue.size() != 0) begin
        w = word_queue.pop_front();
        in_push        <= 1'b1;
        in_func        <= w.func;
        in_stream_byte <= w.b;
        held_word      <= w;
        // hold the word until the block takes it
        do @(posedge clk); while (in_full !== 1'b0);
        burst--;
      end
      // lower push only when a gap follows, so it never toggles within a step
      if (gap > 0 || word_queue.size() == 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Wait until every owed result has come out
  task automatic wait_drained();
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern cycles through steady, every third, coin-flip,
  // mostly-stalled and mostly-popping stretches
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    pop_cyc <= pop_cyc + 1;
    case ((pop_cyc >> 7) % 5)
      0:       out_pop <= 1'b1;
      1:       out_pop <= (pop_cyc % 3 == 0);
      2:       out_pop <= 1'($urandom_range(0, 1));
      3:       out_pop <= ($urandom_range(0, 7) == 0);
      default: out_pop <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input word, check every popped result
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
    result_t    want;
    if (rst_n) begin
      if (in_push && in_full === 1'b0) begin
        words_taken++;
        parse_word(in_func, in_stream_byte, cnt, r0, r1);
        // a table row with known results overrides the tracker's answer
        if (held_word.known) begin
          cnt = held_word.n;
          r0  = held_word.r0;
          r1  = held_word.r1;
        end
        if (cnt > 2'd0)
          expected_results.push_back('{r0.kind, r0.payload, cnt == 2'd1});
        if (cnt > 2'd1)
          expected_results.push_back('{r1.kind, r1.payload, 1'b1});
      end
      if (out_pop && out_empty === 1'b0) begin
        case (out_kind)
          KIND_BYTE:  bytes_seen++;
          KIND_FRAME: frames_seen++;
          KIND_ABORT: aborts_seen++;
          default: ;
        endcase
        if (expected_results.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result kind %0d payload %02h last %0b",
                   $time, out_kind, out_payload, out_last);
        end else begin
          want = expected_results.pop_front();
          if (out_kind !== want.kind) begin
            fail_cnt++;
            $display("%0t: kind expected %0d, got %0d", $time, want.kind, out_kind);
          end
          if (out_payload !== want.payload) begin
            fail_cnt++;
            $display("%0t: payload expected %02h, got %02h",
                     $time, want.payload, out_payload);
          end
          if (out_last !== want.last) begin
            fail_cnt++;
            $display("%0t: last expected %0b, got %0b", $time, want.last, out_last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table first
    for (int i = 0; i < DIR_ROWS; i++)
      word_queue.push_back(DIR_TAB[i]);
    send_words();

    // hold the sender until the block has handed over everything
    wait_drained();

    build_stream(RAND_WORDS);
    send_words();
    wait_drained();

    // catch any stray result after the last expected one
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d input words; saw %0d payload bytes, %0d closed frames, %0d aborts.",
             words_taken, bytes_seen, frames_seen, aborts_seen);
    if (fail_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #3000000;
    $display("Timeout with %0d results still owed.", expected_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sdfp_pkg.sv
rtl/sdfp_front.sv
rtl/sdfp_queue.sv
rtl/sdfp_back.sv
rtl/sse_data_frame_parser.sv
sim/tb_top.sv
